// ----- hdl/bwa_pkg.sv -----
package bwa_pkg;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NO_DATA = 2'd1;
	localparam logic [1:0] STATUS_DROPPED = 2'd2;

	typedef struct packed {
		logic load;      // store one sample
		logic fin;       // loaded sample closes the set
		logic rd_issue;  // read sign entry, advance pointer
		logic nodata;    // emit a no-data result
		logic div_step;  // one quotient bit
		logic div_last;  // final quotient bit, latch scale
		logic out_ram;   // form result from sign entry
	} ctrl_t;

	typedef struct packed {
		logic set_ready;
		logic out_valid;
	} stat_t;

endpackage

// ----- hdl/bwa_ram.sv -----
module bwa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/bwa_ctrl.sv -----
module bwa_ctrl #(
	parameter int SUMW = 29
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_cmd,
	input  logic            in_final,
	input  logic            out_ready,
	input  bwa_pkg::stat_t  stat,
	output logic            in_ready,
	output bwa_pkg::ctrl_t  ctrl
);

	localparam int SCW = $clog2(SUMW);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_RD   = 2'd2;

	logic [1:0]     state_q;
	logic [SCW-1:0] step_q;
	logic           accept;
	logic           is_load;
	logic           is_read;
	logic           step_end;

	assign in_ready = (state_q == ST_IDLE) && (!stat.out_valid || out_ready);
	assign accept   = in_valid && in_ready;
	assign is_load  = accept && (in_cmd == bwa_pkg::CMD_LOAD);
	assign is_read  = accept && (in_cmd == bwa_pkg::CMD_READ);
	assign step_end = (step_q == SCW'(SUMW - 1));

	always_comb begin
		ctrl          = '0;
		ctrl.load     = is_load;
		ctrl.fin      = is_load && in_final;
		ctrl.rd_issue = is_read && stat.set_ready;
		ctrl.nodata   = is_read && !stat.set_ready;
		ctrl.div_step = (state_q == ST_DIV);
		ctrl.div_last = (state_q == ST_DIV) && step_end;
		ctrl.out_ram  = (state_q == ST_RD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (is_load && in_final) begin
						state_q <= ST_DIV;
					end else if (is_read && stat.set_ready) begin
						state_q <= ST_RD;
					end
				end
				ST_DIV: begin
					step_q <= step_q + SCW'(1);
					if (step_end) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hdl/bwa_datapath.sv -----
module bwa_datapath #(
	parameter int DEPTH       = 4096,
	parameter int SAMPLE_BITS = 16,
	parameter int SUMW        = 29
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bwa_pkg::ctrl_t         ctrl,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   out_ready,
	output bwa_pkg::stat_t         stat,
	output logic                   out_valid,
	output logic [SAMPLE_BITS-1:0] out_approx,
	output logic [SAMPLE_BITS-1:0] out_scale,
	output logic                   out_last,
	output logic [1:0]             out_status
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SB = SAMPLE_BITS;

	logic [SUMW-1:0] sum_q;
	logic [CW-1:0]   cnt_q;
	logic [AW-1:0]   rp_q;
	logic [SB-1:0]   scale_q;
	logic            ready_q;
	logic            ovf_q;
	logic [CW-1:0]   rem_q;
	logic [SUMW-1:0] quo_q;
	logic            last_q;
	logic            out_valid_q;

	logic            neg;
	logic [SB-1:0]   mag;
	logic [SUMW-1:0] base_sum;
	logic [CW-1:0]   base_cnt;
	logic            base_ovf;
	logic            room;
	logic [SUMW-1:0] next_sum;
	logic [CW-1:0]   next_cnt;
	logic [CW:0]     rem_sh;
	logic            ge;
	logic [CW:0]     rem_sub;
	logic [SUMW-1:0] quo_next;
	logic            sign_rd;
	logic            rd_last;

	assign neg      = sample[SB-1];
	assign mag      = neg ? (SB'(0) - sample) : sample;
	assign base_sum = ready_q ? '0 : sum_q;
	assign base_cnt = ready_q ? '0 : cnt_q;
	assign base_ovf = ready_q ? 1'b0 : ovf_q;
	assign room     = (base_cnt < CW'(DEPTH));
	assign next_sum = room ? (base_sum + SUMW'(mag)) : base_sum;
	assign next_cnt = room ? (base_cnt + CW'(1)) : base_cnt;

	assign rem_sh   = {rem_q, quo_q[SUMW-1]};
	assign ge       = (rem_sh >= {1'b0, cnt_q});
	assign rem_sub  = rem_sh - {1'b0, cnt_q};
	assign quo_next = {quo_q[SUMW-2:0], ge};

	assign rd_last  = ((CW'(rp_q) + CW'(1)) == cnt_q);

	bwa_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_sign_ram (
		.clk  (clk),
		.we   (ctrl.load && room),
		.waddr(base_cnt[AW-1:0]),
		.wdata(neg),
		.raddr(rp_q),
		.rdata(sign_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			cnt_q   <= '0;
			rp_q    <= '0;
			scale_q <= '0;
			ready_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			if (ctrl.load) begin
				sum_q   <= next_sum;
				cnt_q   <= next_cnt;
				ovf_q   <= base_ovf || !room;
				rp_q    <= '0;
				ready_q <= ctrl.fin;
			end
			if (ctrl.rd_issue) begin
				rp_q <= rd_last ? '0 : rp_q + AW'(1);
			end
			if (ctrl.div_last) begin
				scale_q <= quo_next[SB-1:0];
			end
		end
	end

	// restoring divider, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (ctrl.fin) begin
			rem_q <= '0;
			quo_q <= next_sum;
		end else if (ctrl.div_step) begin
			rem_q <= ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
			quo_q <= quo_next;
		end
		if (ctrl.rd_issue) begin
			last_q <= rd_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.nodata || ctrl.out_ram) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.nodata) begin
			out_approx <= '0;
			out_scale  <= '0;
			out_last   <= 1'b0;
			out_status <= bwa_pkg::STATUS_NO_DATA;
		end else if (ctrl.out_ram) begin
			if (sign_rd) begin
				out_approx <= SB'(0) - scale_q;
			end else if (scale_q[SB-1]) begin
				out_approx <= {1'b0, {(SB-1){1'b1}}};
			end else begin
				out_approx <= scale_q;
			end
			out_scale  <= scale_q;
			out_last   <= last_q;
			out_status <= ovf_q ? bwa_pkg::STATUS_DROPPED : bwa_pkg::STATUS_OK;
		end
	end

	assign out_valid      = out_valid_q;
	assign stat.set_ready = ready_q;
	assign stat.out_valid = out_valid_q;

endmodule

// ----- hdl/binary_weight_approximation.sv -----
// Loads and no-data reads are taken one word per cycle while the block is idle and the output is not stalled.
// A read of a held set passes through the registered sign memory read, then the registered output.
// The final load of a set starts the divider, and no new word is taken until it is done:
// the divider forms one quotient bit per cycle.
// Async active-low reset clears sum, count, pointer, scale and flags;
// the sign memory is not cleared.
module binary_weight_approximation #(
	parameter int DEPTH       = 4096,
	parameter int SAMPLE_BITS = 16,
	localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // sample
	input  logic                   s_axis_tuser,  // cmd
	input  logic                   s_axis_tlast,  // final_sample
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // approx_value, scale
	output logic [1:0]             m_axis_tuser,  // status
	output logic                   m_axis_tlast   // last_out
);

	localparam int SUMW = SAMPLE_BITS + $clog2(DEPTH + 1);

	bwa_pkg::ctrl_t         ctrl;
	bwa_pkg::stat_t         stat;
	logic [SAMPLE_BITS-1:0] out_approx;
	logic [SAMPLE_BITS-1:0] out_scale;

	bwa_ctrl #(
		.SUMW(SUMW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_cmd   (s_axis_tuser),
		.in_final (s_axis_tlast),
		.out_ready(m_axis_tready),
		.stat     (stat),
		.in_ready (s_axis_tready),
		.ctrl     (ctrl)
	);

	bwa_datapath #(
		.DEPTH      (DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS),
		.SUMW       (SUMW)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.out_valid (m_axis_tvalid),
		.out_approx(out_approx),
		.out_scale (out_scale),
		.out_last  (m_axis_tlast),
		.out_status(m_axis_tuser)
	);

	assign m_axis_tdata = OUT_TDATA_W'({out_scale, out_approx});

endmodule

// ----- tb/tb_binary_weight_approximation.sv -----
module tb_binary_weight_approximation;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = 4096;
	localparam int SAMPLE_BITS = 16;
	localparam int RANDOM_WORDS = 1250;
	localparam int CYCLE_LIMIT  = 1000000;

	typedef struct packed {
		logic [15:0] value;
		logic [15:0] scale;
		logic        last;
		logic [1:0]  status;
	} approx_word_t;

	// tracks the held set and queues the words that reads must return
	class sign_scale_scoreboard;
		bit           sign_bits [DEPTH];
		logic [27:0]  mag_sum;
		logic [12:0]  stored;
		logic [11:0]  next_idx;
		logic [15:0]  alpha;
		bit           set_held;
		bit           dropped_any;
		approx_word_t expected_words[$];
		int           errors;

		function new();
			errors = 0;
			drop_set();
		endfunction

		function void drop_set();
			mag_sum     = '0;
			stored      = '0;
			next_idx    = '0;
			alpha       = '0;
			set_held    = 1'b0;
			dropped_any = 1'b0;
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function void note_word(logic cmd, logic [15:0] sample, logic fin);
			approx_word_t w;
			logic [16:0]  mag;
			logic [12:0]  idx;
			if (cmd == bwa_pkg::CMD_LOAD) begin
				mag = sample[15] ? 17'h10000 - {1'b0, sample} : {1'b0, sample};
				if (set_held)
					drop_set();
				if (stored < DEPTH) begin
					sign_bits[stored] = sample[15];
					mag_sum = mag_sum + mag;
					stored = stored + 13'd1;
				end else begin
					dropped_any = 1'b1;
				end
				if (fin) begin
					alpha    = (stored != 0) ? 16'(mag_sum / stored) : 16'd0;
					next_idx = '0;
					set_held = 1'b1;
				end
				return;
			end
			if (!set_held || stored == 0) begin
				w = '{value: 16'd0, scale: 16'd0, last: 1'b0,
					status: bwa_pkg::STATUS_NO_DATA};
			end else begin
				idx = {1'b0, next_idx};
				if (idx >= stored)
					idx = '0;
				w.last   = (idx + 13'd1 == stored);
				w.scale  = alpha;
				w.status = dropped_any ? bwa_pkg::STATUS_DROPPED : bwa_pkg::STATUS_OK;
				if (sign_bits[idx])
					w.value = 16'd0 - alpha;
				else
					w.value = (alpha > 16'h7fff) ? 16'h7fff : alpha;
				next_idx = w.last ? 12'd0 : 12'(idx + 13'd1);
			end
			expected_words.push_back(w);
		endfunction

		function void check_word(approx_word_t got);
			approx_word_t exp_w;
			if (expected_words.size() == 0) begin
				$error("unexpected output word %h", got);
				errors++;
				return;
			end
			exp_w = expected_words.pop_front();
			if (got.value !== exp_w.value) begin
				$error("approx_value: expected %0d, got %0d",
					$signed(exp_w.value), $signed(got.value));
				errors++;
			end
			if (got.scale !== exp_w.scale) begin
				$error("scale: expected %0d, got %0d", exp_w.scale, got.scale);
				errors++;
			end
			if (got.last !== exp_w.last) begin
				$error("last_out: expected %0d, got %0d", exp_w.last, got.last);
				errors++;
			end
			if (got.status !== exp_w.status) begin
				$error("status: expected %0d, got %0d", exp_w.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;  // sample
	logic        s_axis_tuser = 1'b0;  // cmd
	logic        s_axis_tlast = 1'b0;  // final_sample
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;  // approx_value, scale
	logic [1:0]  m_axis_tuser;  // status
	logic        m_axis_tlast;  // last_out

	sign_scale_scoreboard sb = new();
	bit idle_on  = 1'b1;
	bit hold_req = 1'b0;
	int words_sent = 0;

	binary_weight_approximation #(
		.DEPTH(DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("status: fail");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_word({m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tlast, m_axis_tuser});
	end

	// output side: random stalls, one long hold-off on request
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_done = 1'b1;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 11))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hffff;
			4: return 16'h0001;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic put_word(logic cmd, logic [15:0] sample, logic fin);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= sample;
		s_axis_tuser  <= cmd;
		s_axis_tlast  <= fin;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_word(cmd, sample, fin);
		words_sent++;
	endtask

	task automatic load_set(int n, bit close);
		for (int i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(0, 19) == 0)
				put_word(bwa_pkg::CMD_READ, 16'($urandom), 1'($urandom));
			put_word(bwa_pkg::CMD_LOAD, pick_sample(), close && (i == n - 1));
		end
	endtask

	task automatic read_words(int n);
		repeat (n) put_word(bwa_pkg::CMD_READ, 16'($urandom), 1'($urandom));
	endtask

	initial begin
		int base;
		int n;
		bit pressure_done;
		pressure_done = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: read with nothing loaded, extremes, wrap, read mid-load
		put_word(bwa_pkg::CMD_READ, 16'hffff, 1'b1);
		put_word(bwa_pkg::CMD_LOAD, 16'h7fff, 1'b0);
		put_word(bwa_pkg::CMD_LOAD, 16'h8000, 1'b0);
		put_word(bwa_pkg::CMD_LOAD, 16'h0000, 1'b0);
		put_word(bwa_pkg::CMD_LOAD, 16'hffff, 1'b1);
		read_words(5);
		put_word(bwa_pkg::CMD_LOAD, 16'h8000, 1'b1);
		read_words(2);
		put_word(bwa_pkg::CMD_LOAD, 16'h1234, 1'b0);
		put_word(bwa_pkg::CMD_READ, 16'h0000, 1'b0);
		put_word(bwa_pkg::CMD_LOAD, 16'h0000, 1'b1);
		read_words(3);
		put_word(bwa_pkg::CMD_LOAD, 16'h0000, 1'b1);
		read_words(2);
		put_word(bwa_pkg::CMD_LOAD, 16'h8000, 1'b0);
		put_word(bwa_pkg::CMD_LOAD, 16'h7fff, 1'b1);
		read_words(3);

		base = words_sent;
		while (words_sent - base < RANDOM_WORDS) begin
			if (words_sent - base > RANDOM_WORDS - 200)
				idle_on = 1'b0;
			if (!pressure_done && words_sent - base > 300) begin
				load_set($urandom_range(3, 12), 1'b1);
				hold_req = 1'b1;
				read_words(80);
				pressure_done = 1'b1;
			end
			case ($urandom_range(0, 9))
				7: read_words($urandom_range(1, 4));
				8: load_set($urandom_range(1, 10), 1'b0);
				9: begin
					put_word(bwa_pkg::CMD_LOAD, pick_sample(), 1'b1);
					read_words($urandom_range(0, 3));
				end
				default: begin
					n = ($urandom_range(0, 15) == 0) ? $urandom_range(50, 300)
						: $urandom_range(1, 24);
					load_set(n, 1'b1);
					read_words($urandom_range(0, 2 * n + 2));
				end
			endcase
		end
		s_axis_tvalid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- binary_weight_approximation.f -----
hdl/bwa_pkg.sv
hdl/bwa_ram.sv
hdl/bwa_ctrl.sv
hdl/bwa_datapath.sv
hdl/binary_weight_approximation.sv
tb/tb_binary_weight_approximation.sv
